### design/wvest_pkg.sv
// shared types, widths and constants for the windowed velocity estimator
// used by wvest_ring, wvest_div and windowed_velocity_estimator_core
package wvest_pkg;

  localparam int unsigned RingDepthDef = 32;

  localparam int unsigned SampleW  = 32;
  localparam int unsigned WinW     = 5;
  localparam int unsigned ShiftW   = 4;
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned CfgIdxW  = 1;

  // difference of two samples, then up to 15 bits of gain shift
  localparam int unsigned DiffW       = SampleW + 1;
  localparam int unsigned MagW        = 48;
  localparam int unsigned DivStepBits = 2;
  localparam int unsigned DivSteps    = MagW / DivStepBits;
  localparam int unsigned DivCntW     = $clog2(DivSteps);

  localparam logic [WinW-1:0]   WindowLenRst = 5'd29;
  localparam logic [ShiftW-1:0] GainShiftRst = 4'd0;

  localparam logic [SampleW-1:0] SpeedMax = 32'h7FFF_FFFF;
  localparam logic [SampleW-1:0] SpeedMin = 32'h8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_LEN = 1'b0,
    CFG_GAIN_SHIFT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_DIV,
    ST_FINISH
  } seq_state_e;

  // request to the divider
  typedef struct packed {
    logic            start;
    logic [MagW-1:0] dividend;
    logic [WinW-1:0] divisor;
  } div_req_t;

endpackage

### design/wvest_ring.sv
// sample ring: one write port, one registered read port
// depends on wvest_pkg for sample width and default depth
module wvest_ring import wvest_pkg::*; #(
  parameter int unsigned RING_DEPTH = RingDepthDef
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(RING_DEPTH)-1:0] waddr_i,
  input  logic [SampleW-1:0]            wdata_i,
  input  logic [$clog2(RING_DEPTH)-1:0] raddr_i,
  output logic [SampleW-1:0]            rdata_o
);

  logic [SampleW-1:0] mem [RING_DEPTH];
  logic [SampleW-1:0] rdata_q;

  // read returns the old contents when the same slot is written
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/wvest_div.sv
// unsigned radix-4 restoring divider, two quotient bits per cycle
// depends on wvest_pkg for widths and the request struct
module wvest_div import wvest_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  div_req_t        req_i,
  output logic            done_o,
  output logic [MagW-1:0] quotient_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [WinW-1:0]    rem_q, rem_d;
  logic [MagW-1:0]    quo_q, quo_d;
  logic [WinW-1:0]    dvs_q;
  logic [WinW:0]      r_v;
  logic [MagW-1:0]    q_v;

  // dividend shifts out of the top, quotient bits shift in at the bottom
  always_comb begin
    r_v = {1'b0, rem_q};
    q_v = quo_q;
    for (int k = 0; k < DivStepBits; k++) begin
      r_v = {r_v[WinW-1:0], q_v[MagW-1]};
      q_v = {q_v[MagW-2:0], 1'b0};
      if (r_v >= {1'b0, dvs_q}) begin
        r_v    = r_v - {1'b0, dvs_q};
        q_v[0] = 1'b1;
      end
    end
    rem_d = r_v[WinW-1:0];
    quo_d = q_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### design/windowed_velocity_estimator_core.sv
// top level of the windowed velocity estimator, one channel
// depends on wvest_pkg, wvest_ring and wvest_div

// Each accepted position item is written into a ring of RING_DEPTH slots and
// compared with the sample taken window_len items earlier; the difference is
// shifted left by gain_shift, divided by window_len (truncating toward zero)
// and clipped to 32-bit signed, with tuser[0] flagging a clip. A window_len of
// zero acts as one, and a window that is a multiple of the ring depth gives
// zero. Slots not yet written since reset read as the first sample after
// reset, tracked by a fill count, so there is no clearing pass. An item
// passes through the accepting idle step, a ring read, a setup step, the
// divider (24 steps that retire two quotient bits each, then a done step)
// and a finish step; no new item is taken before that finish step. The
// result sits in an output register, so a new item can be accepted while
// the previous result waits; the finish step stalls only if that register
// is still full and not being taken. Configuration is to be written by the
// user only while the block is idle; the block itself does not enforce this.
module windowed_velocity_estimator_core import wvest_pkg::*; #(
  parameter int unsigned RING_DEPTH = RingDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SampleW-1:0]  s_axis_tdata,   // [31:0] position_sample
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [SampleW-1:0]  m_axis_tdata,   // [31:0] speed_estimate
  output logic [0:0]          m_axis_tuser    // [0] saturated
);

  localparam int unsigned IdxW = $clog2(RING_DEPTH);
  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);

  // configuration registers
  logic [WinW-1:0]   win_len_q;
  logic [ShiftW-1:0] gain_q;

  // sequencer and per-channel state
  seq_state_e        state_q, state_d;
  logic [IdxW-1:0]   head_q;
  logic [CntW-1:0]   cnt_q;
  logic [SampleW-1:0] seed_q;

  // item in flight
  logic [SampleW-1:0]      sample_q;
  logic                    same_slot_q;
  logic                    use_seed_q;
  logic signed [DiffW-1:0] diff_q;
  logic                    neg_q;

  // output register
  logic               m_valid_q;
  logic [SampleW-1:0] m_data_q;
  logic               m_sat_q;

  // sequencer outputs
  logic accept;
  logic out_load;

  logic [WinW-1:0]    win_eff;
  logic [IdxW-1:0]    back_lut [32];
  logic [IdxW-1:0]    back;
  logic [IdxW:0]      tail_sum;
  logic [IdxW:0]      tail_wrap;
  logic [IdxW-1:0]    tail;
  logic [CntW-1:0]    cnt_next;
  logic [IdxW-1:0]    head_next;
  logic [SampleW-1:0] ring_rdata;
  logic [SampleW-1:0] old_val;
  logic [DiffW-1:0]   diff_d;
  logic [MagW-1:0]    diff_ext;
  logic [MagW-1:0]    shifted;
  logic [MagW-1:0]    mag;
  div_req_t           div_req;
  logic               div_done;
  logic [MagW-1:0]    quotient;
  logic               sat_pos;
  logic               sat_neg;
  logic [SampleW-1:0] result;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WindowLenRst;
      gain_q    <= GainShiftRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WINDOW_LEN: win_len_q <= cfg_data_i[WinW-1:0];
        CFG_GAIN_SHIFT: gain_q    <= cfg_data_i[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // ring addressing
  // ---------------------------------------------------------------------
  // window of zero behaves as one
  assign win_eff = (win_len_q == '0) ? WinW'(1) : win_len_q;

  // distance back is the window modulo the ring depth, folded at elaboration
  for (genvar g = 0; g < 32; g++) begin : g_back
    assign back_lut[g] = IdxW'(g % RING_DEPTH);
  end
  assign back = back_lut[win_eff];

  // head plus depth minus distance stays below twice the depth
  assign tail_sum  = {1'b0, head_q} + (IdxW+1)'(RING_DEPTH) - {1'b0, back};
  assign tail_wrap = tail_sum - (IdxW+1)'(RING_DEPTH);
  assign tail      = (tail_sum >= (IdxW+1)'(RING_DEPTH)) ? tail_wrap[IdxW-1:0]
                                                          : tail_sum[IdxW-1:0];

  assign cnt_next  = (cnt_q < CntW'(RING_DEPTH)) ? cnt_q + 1'b1 : cnt_q;
  assign head_next = (head_q == IdxW'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;

  wvest_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (head_q),
    .wdata_i (s_axis_tdata),
    .raddr_i (tail),
    .rdata_o (ring_rdata)
  );

  // ---------------------------------------------------------------------
  // datapath around the divider
  // ---------------------------------------------------------------------
  // compared slot is the one just written, one never written, or one read from the ring
  assign old_val = same_slot_q ? sample_q : (use_seed_q ? seed_q : ring_rdata);
  assign diff_d  = {sample_q[SampleW-1], sample_q} - {old_val[SampleW-1], old_val};

  assign diff_ext = {{(MagW-DiffW){diff_q[DiffW-1]}}, diff_q};
  assign shifted  = diff_ext << gain_q;
  assign mag      = shifted[MagW-1] ? (~shifted + 1'b1) : shifted;

  assign div_req.start    = (state_q == ST_PREP);
  assign div_req.dividend = mag;
  assign div_req.divisor  = win_eff;

  wvest_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // clip the magnitude against the range of the sign in use
  assign sat_pos = !neg_q && (quotient[MagW-1:SampleW-1] != '0);
  assign sat_neg = neg_q && ((quotient[MagW-1:SampleW] != '0) ||
                             (quotient[SampleW-1] && (quotient[SampleW-2:0] != '0)));
  always_comb begin
    if (sat_pos) begin
      result = SpeedMax;
    end else if (sat_neg) begin
      result = SpeedMin;
    end else if (neg_q) begin
      result = ~quotient[SampleW-1:0] + 1'b1;
    end else begin
      result = quotient[SampleW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_READ;
        end
      end
      ST_READ:  state_d = ST_PREP;
      ST_PREP:  state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_FINISH: out_load      = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      cnt_q     <= '0;
      seed_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        head_q <= head_next;
        cnt_q  <= cnt_next;
        if (cnt_q == '0) begin
          seed_q <= s_axis_tdata;
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers of the item in flight and of the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q    <= s_axis_tdata;
      same_slot_q <= (tail == head_q);
      // slots at or beyond the fill count are still unwritten
      use_seed_q  <= (CntW'(tail) >= cnt_next);
    end
    if (state_q == ST_READ) begin
      diff_q <= diff_d;
    end
    if (state_q == ST_PREP) begin
      neg_q <= shifted[MagW-1];
    end
    if (out_load) begin
      m_data_q <= result;
      m_sat_q  <= sat_pos || sat_neg;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_sat_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_accept_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_READ)
    else $error("accepted item did not start a ring read");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide step");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == ST_FINISH)
    else $error("result appeared without a finish step");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_sat_q) |-> (m_data_q == SpeedMax || m_data_q == SpeedMin))
    else $error("clipped result is not a range limit");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(RING_DEPTH))
    else $error("fill count ran past the ring depth");

endmodule
